[design/ssap_pkg.sv]
// Package: constants, types and helpers shared by the phaser modules.
package ssap_pkg;

   localparam int StagesDefault = 6;
   localparam int SampleWidthDefault = 16;
   localparam int SineEntriesDefault = 256;
   localparam int IntBits = 24;
   localparam int FracBits = 22;
   localparam int DivBits = 40;

   localparam logic [2:0] CsrSweepMin = 3'd0;
   localparam logic [2:0] CsrSweepMax = 3'd1;
   localparam logic [2:0] CsrLfoStep = 3'd2;
   localparam logic [2:0] CsrFeedback = 3'd3;
   localparam logic [2:0] CsrMixDepth = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SINE, ST_SWEEP, ST_DIV, ST_FEED, ST_READ, ST_MUL1, ST_Y, ST_MUL2,
      ST_M, ST_MIX, ST_OUT
   } state_type;

   // Round right shift, ties toward plus infinity.
   function automatic logic signed [63:0] rsr(input logic signed [63:0] p, input int n);
      begin
         rsr = (p + (64'sd1 <<< (n - 1))) >>> n;
      end
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      begin
         if (v > 64'sd8388607) sat24 = 24'sh7FFFFF;
         else if (v < -64'sd8388608) sat24 = 24'sh800000;
         else sat24 = v[23:0];
      end
   endfunction

endpackage

[design/ssap_if.sv]
// Interfaces: valid/ready stream channel and configuration write channel.
interface ssap_stream_if #(parameter int W = 16) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ssap_csr_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/ssap_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module ssap_ram #(parameter int WIDTH = 24, parameter int DEPTH = 16) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

[design/ssap_div.sv]
// Restoring divider giving the rounded allpass coefficient one bit a cycle.
module ssap_div import ssap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] d,
   output logic        done,
   output logic [23:0] quot
);
   logic [DivBits-1:0] num_ff, num_in;
   logic [17:0] den_ff, den_in;
   logic [17:0] rem_ff, rem_in;
   logic [DivBits-1:0] q_ff, q_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [18:0] trial;

   always_comb begin
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff, num_ff[DivBits-1]};
      if (start) begin
         // Numerator 2*(65536-d)<<22 + den, divided by 2*den, gives rounding.
         num_in = (DivBits'(17'd65536 - 17'(d)) << (FracBits + 1)) + DivBits'(17'd65536 + 17'(d));
         den_in = 18'(17'd65536 + 17'(d)) << 1;
         rem_in = '0; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 18'(trial - {1'b0, den_ff});
            q_in = {q_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in = trial[17:0];
            q_in = {q_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DivBits - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; q_ff <= q_in;
   end

   assign done = busy_ff && cnt_ff == 6'(DivBits - 1);
   assign quot = q_in[23:0];
endmodule

[design/six_stage_allpass_phaser_top.sv]
// Top level: allpass phaser with sine sweep, state held in a small RAM.
//   channel  dir  handshake     payload
//   req      in   valid/ready   sample_in
//   rsp      out  valid/ready   sample_out
//   csr      in   valid/ready   index, data
// A word is taken only in idle and not while the RAM is cleared, so a new word waits until
// the last result is registered for output. The coefficient divider takes most of the time.
// The stage memories sit in one RAM read and written once per stage.
// Reset is synchronous and clears state; the RAM entries of the stages are then zeroed by a sweep.
// A result that waits holds the datapath in its last step; a new word is taken when idle.
module six_stage_allpass_phaser_top import ssap_pkg::*; #(
   parameter int STAGES = StagesDefault,
   parameter int SAMPLE_WIDTH = SampleWidthDefault,
   parameter int SINE_TABLE_ENTRIES = SineEntriesDefault
) (
   input logic clock,
   input logic reset,
   ssap_stream_if.sink req,
   ssap_stream_if.source rsp,
   ssap_csr_if.sink csr
);
   localparam int AW = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int RamDepth = 1 << AW;
   localparam int IW = $clog2(SINE_TABLE_ENTRIES);

   // Quarter-wave sine in Q1.15 from a degree-15 Taylor series in Q30.
   logic [16:0] sine_rom [SINE_TABLE_ENTRIES+1];
   for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_rom
      localparam longint unsigned AngleQ30 =
         (64'd1686629713 * 64'(g)) / 64'(SINE_TABLE_ENTRIES);
      localparam longint unsigned AngleSq = (AngleQ30 * AngleQ30) >> 30;
      localparam longint unsigned Term1 = ((AngleQ30 * AngleSq) >> 30) / 64'd6;
      localparam longint unsigned Term2 = ((Term1 * AngleSq) >> 30) / 64'd20;
      localparam longint unsigned Term3 = ((Term2 * AngleSq) >> 30) / 64'd42;
      localparam longint unsigned Term4 = ((Term3 * AngleSq) >> 30) / 64'd72;
      localparam longint unsigned Term5 = ((Term4 * AngleSq) >> 30) / 64'd110;
      localparam longint unsigned Term6 = ((Term5 * AngleSq) >> 30) / 64'd156;
      localparam longint unsigned Term7 = ((Term6 * AngleSq) >> 30) / 64'd210;
      localparam longint SumQ30 = longint'(AngleQ30) - longint'(Term1) + longint'(Term2)
         - longint'(Term3) + longint'(Term4) - longint'(Term5) + longint'(Term6)
         - longint'(Term7);
      localparam longint EntryQ15 = (((SumQ30 < 64'sd0) ? 64'sd0 : SumQ30) + 64'sd16384) >>> 15;
      assign sine_rom[g] = (EntryQ15 > 64'sd32768) ? 17'd32768 : 17'(EntryQ15);
   end

   state_type state_ff, state_in;
   logic [15:0] smin_ff, smax_ff, mix_ff;
   logic [14:0] fb_ff;
   logic [31:0] step_ff, phase_ff, phase_in;
   logic signed [SAMPLE_WIDTH-1:0] samp_ff, samp_in;
   logic signed [17:0] sine_ff, sine_in;
   logic [15:0] d_ff, d_in;
   logic [23:0] a_ff, a_in;
   logic signed [23:0] xin_ff, xin_in, x_ff, x_in, y_ff, y_in;
   logic signed [47:0] p_ff, p_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic clr_ff, clr_in;
   logic outv_ff, outv_in;
   logic [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [23:0] mem_wdata;
   logic [23:0] rdata;
   logic div_done;
   logic [23:0] div_q;
   logic [IW:0] ridx;
   logic [16:0] sv;
   logic [33:0] dsum;
   logic signed [63:0] t;
   logic div_go_ff;

   ssap_ram #(.WIDTH(24), .DEPTH(RamDepth)) u_ram (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(rdata));

   ssap_div u_div (.clock(clock), .reset(reset), .start(div_go_ff), .d(d_ff),
      .done(div_done), .quot(div_q));

   assign req.ready = state_ff == ST_IDLE && !clr_ff;
   assign rsp.valid = outv_ff;
   assign rsp.data = out_ff;
   assign csr.ready = 1'b1;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; samp_in = samp_ff; sine_in = sine_ff;
      d_in = d_ff; a_in = a_ff; xin_in = xin_ff; x_in = x_ff; y_in = y_ff; p_in = p_ff;
      idx_in = idx_ff; clr_in = clr_ff; outv_in = outv_ff; out_in = out_ff;
      mem_we = 1'b0; mem_waddr = idx_ff; mem_raddr = idx_ff; mem_wdata = '0;
      ridx = '0; sv = '0; dsum = '0; t = '0;
      if (outv_ff && rsp.ready) outv_in = 1'b0;
      if (clr_ff) begin
         mem_we = 1'b1;
         idx_in = idx_ff + AW'(1);
         if (idx_ff == AW'(STAGES - 1)) clr_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               samp_in = req.data;
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            ridx = (IW+1)'(({2'b0, phase_ff[29:0]} * 64'(SINE_TABLE_ENTRIES)) >> 30);
            if (ridx >= (IW+1)'(SINE_TABLE_ENTRIES)) ridx = (IW+1)'(SINE_TABLE_ENTRIES - 1);
            if (phase_ff[30]) sv = sine_rom[(IW+1)'(SINE_TABLE_ENTRIES) - ridx];
            else sv = sine_rom[ridx];
            sine_in = phase_ff[31] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
            phase_in = phase_ff + step_ff;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            dsum = 34'(smin_ff) * 34'(18'sd65536 - (sine_ff + 18'sd32768))
                 + 34'(smax_ff) * 34'(sine_ff + 18'sd32768);
            d_in = dsum[31:16];
            state_in = ST_DIV;
            t = rsr(64'(samp_ff) <<< FracBits, SAMPLE_WIDTH - 1);
            xin_in = sat24(t);
         end
         ST_DIV: begin
            if (div_done) begin
               a_in = div_q;
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            t = 64'(x_ff) * 64'(fb_ff);
            x_in = sat24(64'(xin_ff) + rsr(t, 15));
            idx_in = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_raddr = idx_ff;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p_in = 48'(x_ff) * $signed({1'b0, a_ff});
            state_in = ST_Y;
         end
         ST_Y: begin
            y_in = sat24(64'($signed(rdata)) - rsr(64'(p_ff), FracBits));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p_in = 48'(y_ff) * $signed({1'b0, a_ff});
            state_in = ST_M;
         end
         ST_M: begin
            mem_we = 1'b1; mem_waddr = idx_ff;
            mem_wdata = sat24(rsr(64'(p_ff), FracBits) + 64'(x_ff));
            x_in = y_ff;
            idx_in = idx_ff + AW'(1);
            state_in = (idx_ff == AW'(STAGES - 1)) ? ST_MIX : ST_READ;
         end
         ST_MIX: begin
            p_in = 48'(x_ff) * $signed({1'b0, mix_ff});
            state_in = ST_OUT;
         end
         ST_OUT: begin
            t = 64'(xin_ff) + rsr(64'(p_ff), 15);
            t = rsr(t <<< (SAMPLE_WIDTH - 1), FracBits);
            if (!outv_ff || rsp.ready) begin
               if (t > 64'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1))
                  out_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
               else if (t < -(64'sd1 <<< (SAMPLE_WIDTH - 1)))
                  out_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
               else out_in = t[SAMPLE_WIDTH-1:0];
               outv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else div_go_ff <= state_ff == ST_SWEEP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; phase_ff <= '0; outv_ff <= 1'b0;
         clr_ff <= 1'b1; idx_ff <= '0; x_ff <= '0;
         smin_ff <= 16'd1308; smax_ff <= 16'd4755; step_ff <= 32'd48696;
         fb_ff <= 15'd22938; mix_ff <= 16'd32768;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; outv_ff <= outv_in;
         clr_ff <= clr_in; idx_ff <= idx_in; x_ff <= x_in;
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CsrSweepMin: smin_ff <= csr.data[15:0];
               CsrSweepMax: smax_ff <= csr.data[15:0];
               CsrLfoStep: step_ff <= csr.data;
               CsrFeedback: fb_ff <= csr.data[14:0];
               CsrMixDepth: mix_ff <= csr.data[15:0];
               default: ;
            endcase
         end
      end
      samp_ff <= samp_in; sine_ff <= sine_in; d_ff <= d_in; a_ff <= a_in;
      xin_ff <= xin_in; y_ff <= y_in; p_ff <= p_in; out_ff <= out_in;
   end

   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == ST_SINE)
      else $error("accepted word did not start processing");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (outv_ff && !rsp.ready) |=> (outv_ff && $stable(out_ff)))
      else $error("result dropped or changed while stalled");
   a_clr_block: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req.ready)
      else $error("word accepted during memory clear");
endmodule

[tb/sv/six_stage_allpass_phaser_top_tb.sv]
// Testbench for the six-stage allpass phaser: directed, register and random tests.
module six_stage_allpass_phaser_top_tb import ssap_pkg::*; ();

   localparam int NStages = 6;
   localparam int NSine = 256;
   localparam logic [2:0] CsrUnused = 3'd7;
   localparam int DrainCycles = 120;
   localparam int WatchLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssap_stream_if #(.W(16)) req_bus (clock);
   ssap_stream_if #(.W(16)) rsp_bus (clock);
   ssap_csr_if csr_bus (clock);

   six_stage_allpass_phaser_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr(csr_bus)
   );

   always #1 clock = ~clock;

   // Shadow copy of the registers and state of the phaser.
   longint quarter_sine [0:NSine];
   longint lo_sweep = 1308;
   longint hi_sweep = 4755;
   logic [31:0] phase_step = 32'd48696;
   longint fb_gain = 22938;
   longint wet_gain = 32768;
   logic [31:0] sweep_phase = '0;
   longint stage_mem [NStages];
   longint loop_mem = 0;

   logic signed [15:0] expected_words [$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int csr_writes = 0;
   bit idling_on = 1'b1;
   int stall_left = 0;
   int quiet_cycles = 0;

   function automatic longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -(64'sd1 <<< (bits - 1));
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint round_shift(longint p, int n);
      return (p + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic void build_quarter_sine();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint e;
      for (int i = 0; i <= NSine; i++) begin
         x = 64'd1686629713 * i / NSine;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         e = (sum + (1 << 14)) >>> 15;
         if (e > 32768) e = 32768;
         quarter_sine[i] = e;
      end
   endfunction

   function automatic logic signed [15:0] phase_sample(logic signed [15:0] smp);
      longint sv;
      longint u;
      longint d;
      longint num;
      longint den;
      longint a;
      longint x_in;
      longint x;
      longint y;
      longint o;
      int idx;
      sv = smp;
      idx = sweep_phase[29:22];
      u = sweep_phase[30] ? quarter_sine[NSine - idx] : quarter_sine[idx];
      if (sweep_phase[31]) u = -u;
      u = u + 32768;
      d = (lo_sweep * (65536 - u) + hi_sweep * u) >>> 16;
      sweep_phase = sweep_phase + phase_step;
      num = (65536 - d) <<< FracBits;
      den = 65536 + d;
      a = (num + den / 2) / den;
      x_in = clip(round_shift(sv <<< FracBits, 15), IntBits);
      x = clip(x_in + round_shift(loop_mem * fb_gain, 15), IntBits);
      for (int i = 0; i < NStages; i++) begin
         y = clip(stage_mem[i] - round_shift(a * x, FracBits), IntBits);
         stage_mem[i] = clip(round_shift(a * y, FracBits) + x, IntBits);
         x = y;
      end
      loop_mem = x;
      o = x_in + round_shift(x * wet_gain, 15);
      o = clip(round_shift(o <<< 15, FracBits), 16);
      return 16'(o);
   endfunction

   initial begin
      build_quarter_sine();
      for (int i = 0; i < NStages; i++) stage_mem[i] = 0;
   end

   // Input and register monitor: updates the shadow model at each accepted word and register write.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_words.push_back(phase_sample(req_bus.data));
            words_sent++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            csr_writes++;
            case (csr_bus.index)
               CsrSweepMin: lo_sweep = csr_bus.data[15:0];
               CsrSweepMax: hi_sweep = csr_bus.data[15:0];
               CsrLfoStep: phase_step = csr_bus.data;
               CsrFeedback: fb_gain = csr_bus.data[14:0];
               CsrMixDepth: wet_gain = csr_bus.data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("sample_out: unexpected word %0d", $signed(rsp_bus.data));
            errors++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_bus.data !== want) begin
               $error("sample_out: expected %0d, actual %0d", want, $signed(rsp_bus.data));
               errors++;
            end
         end
      end
   end

   // Receiver with random stall bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("Watchdog expired with %0d words outstanding.", expected_words.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(logic signed [15:0] smp);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= smp;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_all(logic [31:0] smin, logic [31:0] smax, logic [31:0] step,
                          logic [31:0] fb, logic [31:0] mix);
      drain();
      csr_write(CsrSweepMin, smin);
      csr_write(CsrSweepMax, smax);
      csr_write(CsrLfoStep, step);
      csr_write(CsrFeedback, fb);
      csr_write(CsrMixDepth, mix);
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 1) ? 32767 : -32768);
         1: return 16'($signed($urandom_range(0, 512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] fixed_words [10];
      fixed_words = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd32767,
                      16'sd32767, -16'sd32768, -16'sd32768, 16'sd0};
      foreach (fixed_words[i]) send_word(fixed_words[i]);
   endtask

   task automatic test_register_extremes();
      // Downward sweep, phase falling by one per word, strongest feedback, wet gain near two.
      set_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
      csr_write(CsrUnused, 32'h1234_5678);
      for (int i = 0; i < 6; i++) send_word(i % 2 ? 16'sd32767 : -16'sd32768);
      set_all(32'd0, 32'd65535, 32'h4000_0000, 32'd0, 32'd0);
      for (int i = 0; i < 6; i++) send_word(random_sample());
      set_all(32'd0, 32'd0, 32'd0, 32'd32767, 32'd32768);
      for (int i = 0; i < 4; i++) send_word(16'sd32767);
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [31:0] step;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: step = $urandom;
            1: step = $urandom_range(0, 1 << 20);
            2: step = 32'h4000_0000 + $urandom_range(0, 255);
            default: step = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         endcase
         set_all($urandom_range(0, 65535), $urandom_range(0, 65535), step,
                 $urandom_range(0, 1) ? 32'd32767 : $urandom_range(0, 32767),
                 $urandom_range(0, 2) == 0 ? $urandom_range(32768, 65535)
                                           : $urandom_range(0, 32768));
         if (p == phases - 1) idling_on = 1'b0;
         for (int i = 0; i < per_phase; i++) send_word(random_sample());
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random(8, 200);
      drain();
      $display("Checked %0d of %0d words across %0d register writes,", words_checked,
               words_sent, csr_writes);
      $display("covering sweep extremes, full feedback, wet gain above unity and stalls.");
      if (errors == 0 && expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
design/ssap_pkg.sv
design/ssap_if.sv
design/ssap_ram.sv
design/ssap_div.sv
design/six_stage_allpass_phaser_top.sv
tb/sv/six_stage_allpass_phaser_top_tb.sv
